// File: hdl/bur_pkg.sv
package bur_pkg;

    localparam int CAPACITY  = 10;
    localparam int WORDS     = 9;
    localparam int WORD_W    = 32;
    localparam int SLOT_W    = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int IDX_W     = $clog2(WORDS);
    localparam int MEM_DEPTH = CAPACITY * WORDS;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int OUT_W     = 4;
    localparam int S_DATA_W  = WORDS * WORD_W;
    localparam int M_BITS    = 1 + 2 * OUT_W + WORDS * WORD_W;
    localparam int M_DATA_W  = ((M_BITS + 7) / 8) * 8;

    localparam logic [WORD_W-1:0] ONE_F32 = 32'h3F80_0000;

    typedef enum logic [1:0] {
        CMD_ADD  = 2'd0,
        CMD_UNDO = 2'd1,
        CMD_REDO = 2'd2,
        CMD_READ = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_CMP,
        ST_APPEND,
        ST_WRITE,
        ST_READ,
        ST_READ_LAST,
        ST_OUT
    } state_t;

    typedef logic [WORD_W-1:0] word_t;

    // default entry: six zeros then three ones
    function automatic word_t default_word(input logic [IDX_W-1:0] idx);
        word_t w;
        w = (int'(idx) >= WORDS - 3) ? ONE_F32 : '0;
        return w;
    endfunction

endpackage

// File: hdl/bounded_undo_redo_history.sv
// a read or failed undo/redo goes straight to the output, a moving undo or redo
// reads the entry, an equal add compares it, a storing add also writes it; one item
// at a time, the next transfer taken once the result sits in the output register
// the word loops share one 32-bit comparator and one ram (a write and a read port)
// reset: synchronous active-low; after release an init pass writes the
// default entry into slot 0 while s_tready stays low
module bounded_undo_redo_history
    import bur_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // m00, m01, m02, m10, m11, m12, m20, m21, m22
    input  logic [1:0]          s_tuser,   // command
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // done_res, history_count, cursor_pos, cur00..cur22
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WORDS - 1);
    localparam logic [CNT_W-1:0] CAP_C    = CNT_W'(CAPACITY);

    state_t state_reg, state_next;
    cmd_t   cmd_reg, cmd_next;
    word_t  in_reg [WORDS];
    word_t  in_next [WORDS];
    word_t  cur_reg [WORDS];
    word_t  cur_next [WORDS];

    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [IDX_W-1:0]    rd_idx_reg;
    logic                rd_pend_reg;
    logic [SLOT_W-1:0]   oldest_reg, oldest_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    cursor_reg, cursor_next;
    logic                done_reg, done_next;
    logic                diff_reg, diff_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic                s_fire;
    logic                idx_last;
    logic                can_undo;
    logic                can_redo;
    logic                word_ne;
    logic                out_load;
    logic [CNT_W:0]      slot_sum;
    logic [SLOT_W-1:0]   cur_slot;
    logic [CNT_W-1:0]    new_pos;
    logic                wrap;

    logic                ram_wr_en;
    logic [ADDR_W-1:0]   ram_wr_addr;
    word_t               ram_wr_data;
    logic                ram_rd_en;
    logic [ADDR_W-1:0]   ram_rd_addr;
    word_t               ram_rd_data;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign idx_last = (idx_reg == LAST_IDX);
    assign can_undo = (cursor_reg != '0);
    assign can_redo = ({1'b0, cursor_reg} + 1'b1) < {1'b0, count_reg};
    assign word_ne  = (in_reg[idx_reg] != cur_reg[idx_reg]);
    assign out_load = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    // circular slot of the cursor
    assign slot_sum = {1'b0, CNT_W'(oldest_reg)} + {1'b0, cursor_reg};
    always_comb begin
        if (slot_sum >= (CNT_W + 1)'(CAPACITY)) begin
            cur_slot = SLOT_W'(slot_sum - (CNT_W + 1)'(CAPACITY));
        end else begin
            cur_slot = SLOT_W'(slot_sum);
        end
    end

    assign wrap    = (cursor_reg + 1'b1) >= CAP_C;
    assign new_pos = wrap ? CAP_C - 1'b1 : cursor_reg + 1'b1;

    bur_entry_ram #(
        .DEPTH  (MEM_DEPTH),
        .WIDTH  (WORD_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = ADDR_W'(cur_slot) * ADDR_W'(WORDS) + ADDR_W'(idx_reg);
        ram_wr_data = in_reg[idx_reg];
        ram_rd_en   = (state_reg == ST_READ);
        ram_rd_addr = ram_wr_addr;
        if (state_reg == ST_INIT) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = ADDR_W'(idx_reg);
            ram_wr_data = default_word(idx_reg);
        end else if (state_reg == ST_WRITE) begin
            ram_wr_en = 1'b1;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT: begin
                if (idx_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (cmd_reg)
                    CMD_ADD:  state_next = ST_CMP;
                    CMD_UNDO: state_next = can_undo ? ST_READ : ST_OUT;
                    CMD_REDO: state_next = can_redo ? ST_READ : ST_OUT;
                    CMD_READ: state_next = ST_OUT;
                    default:  state_next = ST_OUT;
                endcase
            end
            ST_CMP: begin
                if (idx_last) begin
                    state_next = (diff_reg || word_ne) ? ST_APPEND : ST_OUT;
                end
            end
            ST_APPEND:    state_next = ST_WRITE;
            ST_WRITE: begin
                if (idx_last) begin
                    state_next = ST_OUT;
                end
            end
            ST_READ: begin
                if (idx_last) begin
                    state_next = ST_READ_LAST;
                end
            end
            ST_READ_LAST: state_next = ST_OUT;
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        cmd_next      = cmd_reg;
        in_next       = in_reg;
        cur_next      = cur_reg;
        idx_next      = idx_reg;
        oldest_next   = oldest_reg;
        count_next    = count_reg;
        cursor_next   = cursor_reg;
        done_next     = done_reg;
        diff_next     = diff_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;

        if (rd_pend_reg) begin
            cur_next[rd_idx_reg] = ram_rd_data;
        end

        unique case (state_reg)
            ST_INIT: begin
                idx_next = idx_last ? '0 : idx_reg + 1'b1;
            end
            ST_IDLE: begin
                if (s_fire) begin
                    cmd_next = cmd_t'(s_tuser);
                    for (int k = 0; k < WORDS; k++) begin
                        in_next[k] = s_tdata[k*WORD_W +: WORD_W];
                    end
                end
            end
            ST_DECODE: begin
                idx_next  = '0;
                diff_next = 1'b0;
                done_next = 1'b0;
                unique case (cmd_reg)
                    CMD_UNDO: begin
                        if (can_undo) begin
                            cursor_next = cursor_reg - 1'b1;
                            done_next   = 1'b1;
                        end
                    end
                    CMD_REDO: begin
                        if (can_redo) begin
                            cursor_next = cursor_reg + 1'b1;
                            done_next   = 1'b1;
                        end
                    end
                    CMD_ADD, CMD_READ: begin
                    end
                    default: begin
                    end
                endcase
            end
            ST_CMP: begin
                diff_next = diff_reg || word_ne;
                idx_next  = idx_last ? '0 : idx_reg + 1'b1;
            end
            ST_APPEND: begin
                if (wrap) begin
                    oldest_next = (oldest_reg == SLOT_W'(CAPACITY - 1)) ? '0
                                                                         : oldest_reg + 1'b1;
                end
                cursor_next = new_pos;
                count_next  = new_pos + 1'b1;
                done_next   = 1'b1;
                idx_next    = '0;
            end
            ST_WRITE: begin
                cur_next[idx_reg] = in_reg[idx_reg];
                idx_next          = idx_last ? '0 : idx_reg + 1'b1;
            end
            ST_READ: begin
                idx_next = idx_last ? '0 : idx_reg + 1'b1;
            end
            ST_READ_LAST: begin
            end
            ST_OUT: begin
                if (out_load) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tdata_next[0] = done_reg;
                    m_tdata_next[OUT_W:1] = OUT_W'(count_reg);
                    m_tdata_next[2*OUT_W:OUT_W+1] = OUT_W'(cursor_reg);
                    for (int k = 0; k < WORDS; k++) begin
                        m_tdata_next[1 + 2*OUT_W + k*WORD_W +: WORD_W] = cur_reg[k];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            cmd_reg      <= CMD_READ;
            idx_reg      <= '0;
            rd_pend_reg  <= 1'b0;
            oldest_reg   <= '0;
            count_reg    <= CNT_W'(1);
            cursor_reg   <= '0;
            done_reg     <= 1'b0;
            diff_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int k = 0; k < WORDS; k++) begin
                cur_reg[k] <= default_word(IDX_W'(k));
            end
        end else begin
            state_reg    <= state_next;
            cmd_reg      <= cmd_next;
            idx_reg      <= idx_next;
            rd_pend_reg  <= ram_rd_en;
            oldest_reg   <= oldest_next;
            count_reg    <= count_next;
            cursor_reg   <= cursor_next;
            done_reg     <= done_next;
            diff_reg     <= diff_next;
            m_tvalid_reg <= m_tvalid_next;
            cur_reg      <= cur_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg      <= in_next;
        rd_idx_reg  <= idx_reg;
        m_tdata_reg <= m_tdata_next;
    end

`ifndef SYNTHESIS
    a_cursor_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cursor_reg < count_reg)
        else $error("cursor beyond newest entry");

    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != '0) && (count_reg <= CAP_C))
        else $error("entry count out of range");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_tready)
        else $error("second transfer taken while busy");

    a_no_write_when_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !ram_wr_en)
        else $error("store written while idle");
`endif

endmodule

// File: hdl/bur_entry_ram.sv
module bur_entry_ram #(
    parameter int DEPTH  = 90,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
